[rtl/sha256_byte_stream_hasher_defines.svh]
// Assertion macros for the SHA-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHAB_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SHAB_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SHAB_ASSERT_IMPL(label, clk, rst_n, a, b)
`define SHAB_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/shab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shab_pkg
// Types, round constants and functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package shab_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [6:0] BLOCK_FULL = 7'd64;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] v, input int amt);
        ror = (v >> amt) | (v << (32 - amt));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] v);
        big_sig0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] v);
        big_sig1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] v);
        small_sig0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] v);
        small_sig1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        case (i)
            6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

[rtl/shab_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shab_in_if / shab_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface shab_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface shab_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps
// A byte that does not fill a block is only stored; a full block runs the round
// loop: a load step, 64 rounds and a chain update.
// At the end of a message one or two more blocks run the loop, then 8 digest words.
// Bytes are taken only in IDLE: no byte is accepted while a block is hashed or the digest is out.
// Reset (synchronous, active low): initial hash values, empty block, length 0.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// Byte-wide SHA-256 with the block kept in a 16x32 word memory.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    shab_in_if.sink    i_in,
    shab_out_if.source o_out
);

    shab_pkg::t_state r_state, n_state;

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;
    logic [3:0]  rd_addr;

    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_t;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_pad, r_mark, r_len, r_pend_end;
    logic [2:0]  r_oidx;

    logic        in_acc, out_acc;
    logic [6:0]  fill_inc;
    logic [31:0] word_in, wt, t1, t2;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign fill_inc = {1'b0, r_fill} + 7'd1;

    assign i_in.ready        = (r_state == shab_pkg::ST_IDLE);
    assign o_out.valid       = (r_state == shab_pkg::ST_OUT);
    assign o_out.digest_word = r_chain[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);

    assign rd_addr = (r_state == shab_pkg::ST_ROUND) ? (r_t[3:0] + 4'd1) : 4'd0;

    // block memory: byte writes, registered word read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.byte_present) begin
            r_mem[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_in.data_byte;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // padding applied on the fly as words leave the memory
    always_comb begin
        logic [5:0] p;
        for (int k = 0; k < 4; k++) begin
            p = {r_t[3:0], 2'(k)};
            if (!r_pad || p < r_fill) begin
                word_in[(3 - k) * 8 +: 8] = r_rdata[(3 - k) * 8 +: 8];
            end else if (r_mark && p == r_fill) begin
                word_in[(3 - k) * 8 +: 8] = shab_pkg::PAD_MARK;
            end else begin
                word_in[(3 - k) * 8 +: 8] = 8'h00;
            end
        end
        if (r_len && r_t[3:0] == 4'd14) begin
            word_in = r_bits[63:32];
        end else if (r_len && r_t[3:0] == 4'd15) begin
            word_in = r_bits[31:0];
        end
    end

    assign wt = (r_t < 6'd16) ? word_in
              : shab_pkg::small_sig1(r_w[14]) + r_w[9]
                + shab_pkg::small_sig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + shab_pkg::big_sig1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + shab_pkg::round_k(r_t) + wt;
    assign t2 = shab_pkg::big_sig0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shab_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present && fill_inc == shab_pkg::BLOCK_FULL) begin
                        n_state = shab_pkg::ST_LOAD;
                    end else if (i_in.end_of_message) begin
                        n_state = shab_pkg::ST_LOAD;
                    end
                end
            end
            shab_pkg::ST_LOAD:  n_state = shab_pkg::ST_ROUND;
            shab_pkg::ST_ROUND: begin
                if (r_t == 6'd63) begin
                    n_state = shab_pkg::ST_FINAL;
                end
            end
            shab_pkg::ST_FINAL: begin
                if (r_len) begin
                    n_state = shab_pkg::ST_OUT;
                end else if (r_pad || r_pend_end) begin
                    n_state = shab_pkg::ST_LOAD;
                end else begin
                    n_state = shab_pkg::ST_IDLE;
                end
            end
            shab_pkg::ST_OUT: begin
                if (out_acc && r_oidx == 3'd7) begin
                    n_state = shab_pkg::ST_IDLE;
                end
            end
            default: n_state = shab_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shab_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= shab_pkg::init_hash(3'(i));
            end
            r_fill     <= '0;
            r_bits     <= '0;
            r_pad      <= 1'b0;
            r_mark     <= 1'b0;
            r_len      <= 1'b0;
            r_pend_end <= 1'b0;
            r_oidx     <= '0;
            r_t        <= '0;
        end else begin
            unique case (r_state)
                shab_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_pend_end <= 1'b0;
                        r_pad      <= 1'b0;
                        r_mark     <= 1'b0;
                        r_len      <= 1'b0;
                        if (i_in.byte_present) begin
                            r_bits <= r_bits + 64'd8;
                            r_fill <= fill_inc[5:0];
                        end
                        if (i_in.byte_present && fill_inc == shab_pkg::BLOCK_FULL) begin
                            r_pend_end <= i_in.end_of_message;
                        end else if (i_in.end_of_message) begin
                            r_pad  <= 1'b1;
                            r_mark <= 1'b1;
                            r_len  <= (i_in.byte_present ? fill_inc[5:0] : r_fill)
                                      < shab_pkg::LENGTH_POS;
                        end
                    end
                end
                shab_pkg::ST_LOAD: begin
                    r_t <= '0;
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_chain[i];
                    end
                end
                shab_pkg::ST_ROUND: begin
                    r_t <= r_t + 6'd1;
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[15] <= wt;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                end
                shab_pkg::ST_FINAL: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_oidx <= '0;
                    if (!r_len) begin
                        if (r_pad) begin
                            // mark block spilled past the length field: length-only block
                            r_mark <= 1'b0;
                            r_fill <= '0;
                            r_len  <= 1'b1;
                        end else if (r_pend_end) begin
                            r_pend_end <= 1'b0;
                            r_pad      <= 1'b1;
                            r_mark     <= 1'b1;
                            r_len      <= 1'b1;
                        end
                    end
                end
                shab_pkg::ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= shab_pkg::init_hash(3'(i));
                            end
                            r_fill <= '0;
                            r_bits <= '0;
                            r_pad  <= 1'b0;
                            r_mark <= 1'b0;
                            r_len  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `SHAB_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `SHAB_ASSERT_NEXT(a_round_end, i_clk, i_rst_n,
        (r_state == shab_pkg::ST_ROUND) && (r_t == 6'd63), r_state == shab_pkg::ST_FINAL)
    `SHAB_ASSERT_NEXT(a_digest_done, i_clk, i_rst_n,
        out_acc && o_out.last_word, (r_bits == 64'd0) && (r_fill == 6'd0))

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream SHA-256 hasher check: messages of random length go in one byte
// per transaction, and every digest word that comes out is compared with a
// software SHA-256 computed alongside, under random gaps and long back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    shab_in_if  in_ch();
    shab_out_if out_ch();

    sha256_byte_stream_hasher dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // software hash state
    logic [31:0] hash_h[8];
    logic [7:0]  blk[64];
    int          blk_fill;
    logic [63:0] msg_bits;

    t_digest_word digest_q[$];
    int           err_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;
    int           quiet_cycles;

    localparam logic [31:0] HASH_START[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_TAB[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w[64];
        logic [31:0] a[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) a[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = a[7] + (rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25))
               + ((a[4] & a[5]) ^ (~a[4] & a[6])) + K_TAB[i] + w[i];
            t2 = (rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22))
               + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
            a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
            a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += a[i];
    endtask

    task automatic hash_restart();
        for (int i = 0; i < 8; i++) hash_h[i] = HASH_START[i];
        blk_fill = 0;
        msg_bits = '0;
    endtask

    // advance the software hash by one accepted transaction
    task automatic hash_accept(input logic [7:0] b, input logic pres, input logic eom);
        int p;
        t_digest_word dw;
        if (pres) begin
            blk[blk_fill] = b;
            blk_fill++;
            msg_bits += 64'd8;
            if (blk_fill == 64) begin
                compress_blk();
                blk_fill = 0;
            end
        end
        if (!eom) return;
        p = blk_fill;
        blk[p++] = 8'h80;
        if (p > 56) begin
            while (p < 64) blk[p++] = 8'h00;
            compress_blk();
            p = 0;
        end
        while (p < 56) blk[p++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
        compress_blk();
        for (int i = 0; i < 8; i++) begin
            dw.word = hash_h[i];
            dw.idx  = 3'(i);
            dw.last = (i == 7);
            digest_q.push_back(dw);
        end
        hash_restart();
    endtask

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // sends one transaction, idling at random beforehand
    task automatic send_byte(input logic [7:0] b, input logic pres, input logic eom);
        while (($urandom % 100) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.byte_present   <= pres;
        in_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!in_ch.ready);
        hash_accept(b, pres, eom);
        @(negedge i_clk);
    endtask

    task automatic send_msg(input int len, input bit bare_end);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && !bare_end)
                send_byte(8'($urandom), 1'b1, 1'b1);
            else
                send_byte(8'($urandom), 1'b1, 1'b0);
            // occasional idle item inside a message
            if (($urandom % 16) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
        end
        if (bare_end || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (digest_q.size() != 0);
    endtask

    // receiver ready and result check
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else
            out_ch.ready <= (($urandom % 100) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_digest_word e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_q.size() == 0) begin
                $error("digest word with none expected: %h", out_ch.digest_word);
                err_count++;
            end else begin
                e = digest_q.pop_front();
                if (out_ch.digest_word !== e.word) begin
                    $error("digest_word exp %h got %h", e.word, out_ch.digest_word);
                    err_count++;
                end
                if (out_ch.word_index !== e.idx) begin
                    $error("word_index exp %0d got %0d", e.idx, out_ch.word_index);
                    err_count++;
                end
                if (out_ch.last_word !== e.last) begin
                    $error("last_word exp %0d got %0d", e.last, out_ch.last_word);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_byte(8'h00, 1'b0, 1'b1);            // empty message
        send_byte(8'h61, 1'b1, 1'b0);            // "abc"
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);            // idle item
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h5a, 1'b0, 1'b1);            // bare end after bytes
        send_byte(8'hff, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_block_edges();
        // pad spills into an extra block; end on the byte that fills a block
        send_msg(56, 1'b1);
        send_msg(64, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(0, 20);
            send_msg(len, $urandom % 2);
            sent += len + 1;
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        send_msg(10, 1'b0);
        send_msg(4, 1'b1);
        send_msg(3, 1'b0);
        wait_drained();                          // sender pauses until drained
        send_msg(5, 1'b0);
        wait_drained();
    endtask

    initial begin
        int tail;
        err_count     = 0;
        quiet_cycles  = 0;
        hold_cycles   = 0;
        send_idle_pct = 32;
        recv_idle_pct = 73;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = 8'h00;
        in_ch.byte_present   = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready         = 1'b0;
        hash_restart();
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_block_edges();
        test_random(40);
        send_idle_pct = 73;
        recv_idle_pct = 32;
        test_random(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(40);
        test_backpressure();

        wait_drained();
        tail = 0;
        while (tail < 300) begin
            @(posedge i_clk);
            tail++;
        end
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/shab_pkg.sv
rtl/shab_ifs.sv
rtl/sha256_byte_stream_hasher.sv
sim/tb_top.sv
